// ===== src/checked_ssa_integer_evaluator_top_assert.svh =====
// Assertion macros for the checked SSA integer evaluator.
// Used by the port checker; no other dependencies.
`ifndef CHECKED_SSA_INTEGER_EVALUATOR_TOP_ASSERT_SVH
`define CHECKED_SSA_INTEGER_EVALUATOR_TOP_ASSERT_SVH

// property must hold at every edge outside reset
`define CSIE_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("csie assertion failed");

// condition must never be seen outside reset
`define CSIE_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("csie forbidden condition");

`endif

// ===== src/csie_pkg.sv =====
// Shared constants and types for the checked SSA integer evaluator.
// No dependencies.
package csie_pkg;
	localparam int SLOT_COUNT = 256;
	localparam int SLOT_W = $clog2(SLOT_COUNT);
	localparam int POS_W = $clog2(SLOT_COUNT + 1);

	localparam logic [2:0] OP_CONST = 3'd0;
	localparam logic [2:0] OP_ADD = 3'd1;
	localparam logic [2:0] OP_SUB = 3'd2;
	localparam logic [2:0] OP_MUL = 3'd3;
	localparam logic [2:0] OP_REM = 3'd4;
	localparam logic [2:0] OP_NEG = 3'd5;
	localparam logic [2:0] OP_RET = 3'd6;
	localparam logic [2:0] OP_BAD = 3'd7;

	localparam logic [1:0] FLT_NONE = 2'd0;
	localparam logic [1:0] FLT_OVF = 2'd1;
	localparam logic [1:0] FLT_NEG = 2'd2;
	localparam logic [1:0] FLT_DIV0 = 2'd3;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_INVALID = 3'd4;

	typedef struct packed {
		logic start;
		logic [2:0] op;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic [1:0] fault;
	} alu_rsp_t;
endpackage

// ===== src/csie_alu.sv =====
// Checked 64-bit arithmetic unit: add/sub/neg in one step, mul and rem
// bit-serial over one shared 66-bit adder. Depends on csie_pkg.
module csie_alu (
	input logic clk,
	input logic arst_n,
	input csie_pkg::alu_req_t req,
	input logic [63:0] a,
	input logic [63:0] b,
	output csie_pkg::alu_rsp_t rsp,
	output logic [63:0] result
);
	import csie_pkg::*;

	typedef enum logic [3:0] {
		U_IDLE = 4'b0001,
		U_MUL = 4'b0010,
		U_REM = 4'b0100,
		U_FIN = 4'b1000
	} ustate_t;

	ustate_t state_q;
	logic [5:0] cnt_q;
	logic [127:0] p_q;
	logic [63:0] ua_q, ub_q, res_q;
	logic a_neg_q, neg_q, is_mul_q, done_q;
	logic [1:0] fault_q;

	logic [63:0] mag_a, mag_b, sum_ab, dif_ab, limit;
	logic [64:0] op_x, op_y, rem_t;
	logic [65:0] sum;
	logic cin, mul_ovf;

	assign mag_a = a[63] ? 64'd0 - a : a;
	assign mag_b = b[63] ? 64'd0 - b : b;
	assign sum_ab = a + b;
	assign dif_ab = a - b;
	assign limit = neg_q ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
	assign mul_ovf = (|p_q[127:64]) || (p_q[63:0] > limit);

	// shared adder: accumulate for mul, trial subtract for rem
	assign rem_t = {p_q[127:64], p_q[63]};
	always_comb begin
		if (state_q == U_MUL) begin
			op_x = {1'b0, p_q[127:64]};
			op_y = p_q[0] ? {1'b0, ua_q} : 65'd0;
			cin = 1'b0;
		end else begin
			op_x = rem_t;
			op_y = ~{1'b0, ub_q};
			cin = 1'b1;
		end
	end
	assign sum = {1'b0, op_x} + {1'b0, op_y} + {65'd0, cin};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				U_IDLE: begin
					if (req.start) begin
						a_neg_q <= a[63];
						neg_q <= a[63] ^ b[63];
						ua_q <= mag_a;
						ub_q <= mag_b;
						cnt_q <= '0;
						fault_q <= FLT_NONE;
						res_q <= '0;
						case (req.op)
							OP_ADD: begin
								if (a[63] == b[63] && sum_ab[63] != a[63])
									fault_q <= FLT_OVF;
								else
									res_q <= sum_ab;
								done_q <= 1'b1;
							end
							OP_SUB: begin
								if (a[63] != b[63] && dif_ab[63] != a[63])
									fault_q <= FLT_OVF;
								else
									res_q <= dif_ab;
								done_q <= 1'b1;
							end
							OP_NEG: begin
								if (a == 64'h8000_0000_0000_0000)
									fault_q <= FLT_NEG;
								else
									res_q <= 64'd0 - a;
								done_q <= 1'b1;
							end
							OP_MUL: begin
								p_q <= {64'd0, mag_b};
								is_mul_q <= 1'b1;
								state_q <= U_MUL;
							end
							OP_REM: begin
								if (b == 64'd0) begin
									fault_q <= FLT_DIV0;
									done_q <= 1'b1;
								end else begin
									p_q <= {64'd0, mag_a};
									is_mul_q <= 1'b0;
									state_q <= U_REM;
								end
							end
							default: done_q <= 1'b1;
						endcase
					end
				end
				U_MUL: begin
					p_q <= {sum[64:0], p_q[63:1]};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) state_q <= U_FIN;
				end
				U_REM: begin
					p_q[127:64] <= sum[65] ? sum[63:0] : rem_t[63:0];
					p_q[63:0] <= {p_q[62:0], 1'b0};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) state_q <= U_FIN;
				end
				U_FIN: begin
					if (is_mul_q) begin
						if (mul_ovf) fault_q <= FLT_OVF;
						else res_q <= neg_q ? 64'd0 - p_q[63:0] : p_q[63:0];
					end else begin
						res_q <= a_neg_q ? 64'd0 - p_q[127:64] : p_q[127:64];
					end
					done_q <= 1'b1;
					state_q <= U_IDLE;
				end
				default: state_q <= U_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.fault = fault_q;
	assign result = res_q;
endmodule

// ===== src/checked_ssa_integer_evaluator_top.sv =====
// Throughput: one request at a time. Mul and rem run 64 bit-serial steps in the unit.
// Return: the result is registered in S_EXEC and shown in S_OUT; then waits on out_stall.
// in_stall is high from accept until the request retires.
// arst_n clears sequencer, position and fault state; the slot memory is not cleared,
// every slot read by a well-formed program is written earlier in that program.
module checked_ssa_integer_evaluator_top (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [2:0] opcode,
	input logic [7:0] left_slot,
	input logic [7:0] right_slot,
	input logic signed [63:0] immediate,
	output logic out_valid,
	input logic out_stall,
	output logic [2:0] status,
	output logic signed [63:0] result_value,
	output logic [7:0] fault_position
);
	import csie_pkg::*;

	// sequencer: read left slot, read right slot, check and dispatch, wait, emit
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RD_A = 6'b000010,
		S_RD_B = 6'b000100,
		S_EXEC = 6'b001000,
		S_WAIT = 6'b010000,
		S_OUT = 6'b100000
	} state_t;

	state_t state_q;
	logic [2:0] op_q;
	logic [7:0] ls_q, rs_q;
	logic [63:0] imm_q, a_q, rdata_q;
	logic [POS_W-1:0] pos_q;
	logic invalid_q;
	logic [1:0] fault_code_q;
	logic [7:0] fault_slot_q;
	logic [2:0] status_q;
	logic [63:0] value_q;
	logic [7:0] fpos_q;

	logic [63:0] slots_mem [SLOT_COUNT];
	logic [SLOT_W-1:0] raddr;
	logic we;
	logic [63:0] wdata;

	alu_req_t alu_req;
	alu_rsp_t alu_rsp;
	logic [63:0] alu_res;

	logic room, bad_req, uses_a, uses_b, inv_next;

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign status = status_q;
	assign result_value = value_q;
	assign fault_position = fpos_q;

	// validity of the request in flight, evaluated in S_EXEC
	assign room = pos_q < POS_W'(SLOT_COUNT);
	assign uses_a = (op_q >= OP_ADD) && (op_q <= OP_RET);
	assign uses_b = (op_q >= OP_ADD) && (op_q <= OP_REM);
	assign bad_req = !room
		|| (op_q != OP_CONST && imm_q != 64'd0)
		|| (op_q == OP_BAD)
		|| (uses_a && (POS_W'(ls_q) >= pos_q))
		|| (uses_b && (POS_W'(rs_q) >= pos_q))
		|| (op_q == OP_RET && pos_q == '0);
	assign inv_next = invalid_q || bad_req;

	assign raddr = (state_q == S_RD_A) ? ls_q[SLOT_W-1:0] : rs_q[SLOT_W-1:0];

	// slot write: direct for const/opcode 7, from the unit otherwise
	always_comb begin
		we = 1'b0;
		wdata = alu_res;
		if (state_q == S_EXEC && op_q != OP_RET && room
				&& (op_q == OP_CONST || op_q == OP_BAD)) begin
			we = 1'b1;
			wdata = (op_q == OP_CONST) ? imm_q : 64'd0;
		end else if (state_q == S_WAIT && alu_rsp.done) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) slots_mem[pos_q[SLOT_W-1:0]] <= wdata;
		rdata_q <= slots_mem[raddr];
	end

	assign alu_req.start = (state_q == S_EXEC) && room && uses_b
		|| (state_q == S_EXEC) && room && (op_q == OP_NEG);
	assign alu_req.op = op_q;

	csie_alu u_alu (
		.clk(clk),
		.arst_n(arst_n),
		.req(alu_req),
		.a(a_q),
		.b(rdata_q),
		.rsp(alu_rsp),
		.result(alu_res)
	);

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			op_q <= opcode;
			ls_q <= left_slot;
			rs_q <= right_slot;
			imm_q <= immediate;
		end
		if (state_q == S_RD_B) a_q <= rdata_q;
		if (state_q == S_EXEC && op_q == OP_RET) begin
			if (inv_next) begin
				status_q <= ST_INVALID;
				value_q <= '0;
				fpos_q <= '0;
			end else if (fault_code_q != FLT_NONE) begin
				status_q <= {1'b0, fault_code_q};
				value_q <= '0;
				fpos_q <= fault_slot_q;
			end else begin
				status_q <= ST_OK;
				value_q <= a_q;
				fpos_q <= pos_q[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pos_q <= '0;
			invalid_q <= 1'b0;
			fault_code_q <= FLT_NONE;
			fault_slot_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_RD_A;
				S_RD_A: state_q <= S_RD_B;
				S_RD_B: state_q <= S_EXEC;
				S_EXEC: begin
					invalid_q <= inv_next;
					if (op_q == OP_RET) begin
						state_q <= S_OUT;
					end else if (!room) begin
						state_q <= S_IDLE;
					end else if (op_q == OP_CONST || op_q == OP_BAD) begin
						pos_q <= pos_q + POS_W'(1);
						state_q <= S_IDLE;
					end else begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (alu_rsp.done) begin
						// only the first fault of a program is kept
						if (alu_rsp.fault != FLT_NONE && fault_code_q == FLT_NONE) begin
							fault_code_q <= alu_rsp.fault;
							fault_slot_q <= pos_q[7:0];
						end
						pos_q <= pos_q + POS_W'(1);
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (!out_stall) begin
						pos_q <= '0;
						invalid_q <= 1'b0;
						fault_code_q <= FLT_NONE;
						fault_slot_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== src/csie_checker.sv =====
// Port-level checker for the evaluator top, bound to every instance.
// Depends on checked_ssa_integer_evaluator_top_assert.svh and csie_pkg.
`include "checked_ssa_integer_evaluator_top_assert.svh"
module csie_checker (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [2:0] status,
	input logic [63:0] result_value,
	input logic [7:0] fault_position
);
	import csie_pkg::*;

	`CSIE_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(status) && $stable(result_value) && $stable(fault_position))
	`CSIE_NEVER(a_status_code, clk, arst_n, out_valid && (status > ST_INVALID))
	`CSIE_NEVER(a_fault_zero, clk, arst_n, out_valid && status != ST_OK && result_value != 64'd0)
	`CSIE_NEVER(a_inv_pos, clk, arst_n, out_valid && status == ST_INVALID && fault_position != 8'd0)
	`CSIE_NEVER(a_busy_out, clk, arst_n, out_valid && !in_stall)
endmodule

bind checked_ssa_integer_evaluator_top csie_checker u_csie_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.status(status),
	.result_value(result_value),
	.fault_position(fault_position)
);

// ===== tb/tb_checked_ssa_integer_evaluator_top.sv =====
// Testbench for the checked SSA integer evaluator top level.
// Predicts program results in a scoreboard class; depends on csie_pkg and the top module.
`timescale 1ns / 1ps

module tb_checked_ssa_integer_evaluator_top;
	import csie_pkg::*;

	localparam int STALL_LIMIT = 5000;	// cycles with no accept before giving up
	localparam int HOLD_CYCLES = 400;	// long receiver hold-off
	localparam int DRAIN_CYCLES = 100;	// settle time after the last result

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [2:0] opcode;
	logic [7:0] left_slot;
	logic [7:0] right_slot;
	logic signed [63:0] immediate;
	logic out_valid;
	logic out_stall;
	logic [2:0] status;
	logic signed [63:0] result_value;
	logic [7:0] fault_position;

	checked_ssa_integer_evaluator_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.left_slot(left_slot),
		.right_slot(right_slot),
		.immediate(immediate),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.result_value(result_value),
		.fault_position(fault_position)
	);

	typedef struct {
		logic [2:0] st;
		logic [63:0] val;
		logic [7:0] fpos;
	} eval_result_t;

	// Shadow evaluator: slot file, position and fault state, plus the
	// queue of results that returns have produced but the block has not shown.
	class csie_scoreboard;
		logic [63:0] slots[SLOT_COUNT];
		int unsigned pos;
		bit bad_prog;
		logic [1:0] flt;
		logic [7:0] flt_pos;
		eval_result_t returns_due[$];
		int errors;

		function new();
			pos = 0;
			bad_prog = 0;
			flt = FLT_NONE;
			flt_pos = '0;
			errors = 0;
		endfunction

		function void note_fault(logic [1:0] code);
			if (flt == FLT_NONE) begin
				flt = code;
				flt_pos = pos[7:0];
			end
		endfunction

		function logic [63:0] evaluate(logic [2:0] op, logic [63:0] a, logic [63:0] b);
			logic [63:0] r;
			logic signed [127:0] prod;
			longint sa;
			longint sb;
			sa = a;
			sb = b;
			r = '0;
			case (op)
				OP_ADD: begin
					r = a + b;
					if (a[63] == b[63] && r[63] != a[63]) begin
						note_fault(FLT_OVF);
						r = '0;
					end
				end
				OP_SUB: begin
					r = a - b;
					if (a[63] != b[63] && r[63] != a[63]) begin
						note_fault(FLT_OVF);
						r = '0;
					end
				end
				OP_MUL: begin
					prod = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
					if (prod[127:63] != {65{prod[63]}}) begin
						note_fault(FLT_OVF);
						r = '0;
					end else begin
						r = prod[63:0];
					end
				end
				OP_REM: begin
					if (b == 0) begin
						note_fault(FLT_DIV0);
					end else if (a == 64'h8000000000000000 && b == '1) begin
						r = '0;
					end else begin
						r = sa % sb;	// truncating: sign follows the dividend
					end
				end
				OP_NEG: begin
					if (a == 64'h8000000000000000) note_fault(FLT_NEG);
					else r = -a;
				end
				default: r = '0;
			endcase
			return r;
		endfunction

		function void note_request(logic [2:0] op, logic [7:0] ls, logic [7:0] rs,
				logic [63:0] imm);
			logic [63:0] a;
			logic [63:0] b;
			bit room;
			eval_result_t res;
			a = '0;
			b = '0;
			room = pos < SLOT_COUNT;
			if (!room) bad_prog = 1;
			if (op != OP_CONST && imm != 0) bad_prog = 1;
			if (op == OP_BAD) bad_prog = 1;
			if (op >= OP_ADD && op <= OP_RET) begin
				if (ls < pos) a = slots[ls];
				else bad_prog = 1;
			end
			if (op >= OP_ADD && op <= OP_REM) begin
				if (rs < pos) b = slots[rs];
				else bad_prog = 1;
			end
			if (op == OP_RET) begin
				if (pos == 0) bad_prog = 1;
				if (bad_prog) begin
					res = '{ST_INVALID, '0, '0};
				end else if (flt != FLT_NONE) begin
					res = '{{1'b0, flt}, '0, flt_pos};
				end else begin
					res = '{ST_OK, a, pos[7:0]};
				end
				returns_due.push_back(res);
				pos = 0;
				bad_prog = 0;
				flt = FLT_NONE;
				flt_pos = '0;
			end else if (room) begin
				if (op == OP_CONST) slots[pos] = imm;
				else slots[pos] = evaluate(op, a, b);
				pos++;
			end
		endfunction

		function void check_result(logic [2:0] st, logic [63:0] val, logic [7:0] fp);
			eval_result_t want;
			if (returns_due.size() == 0) begin
				$error("unexpected result: status %0d value %0h", st, val);
				errors++;
				return;
			end
			want = returns_due.pop_front();
			if (st !== want.st) begin
				$error("status: expected %0d actual %0d", want.st, st);
				errors++;
			end
			if (val !== want.val) begin
				$error("result_value: expected %0h actual %0h", want.val, val);
				errors++;
			end
			if (fp !== want.fpos) begin
				$error("fault_position: expected %0d actual %0d", want.fpos, fp);
				errors++;
			end
		endfunction

		function int outstanding();
			return returns_due.size();
		endfunction
	endclass

	csie_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_req;
	int hold_left;
	int quiet_cycles;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Monitor: both handshakes sampled at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) sb.note_request(opcode, left_slot, right_slot, immediate);
			if (out_valid && !out_stall) sb.check_result(status, result_value, fault_position);
		end
	end

	// Watchdog: any accept on either side resets the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Receiver: random stall, or a long hold-off on request.
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// Drive one request from a falling edge; returns at the falling edge after accept.
	task automatic send(logic [2:0] op, logic [7:0] ls, logic [7:0] rs, logic [63:0] imm);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid = 1;
		opcode = op;
		left_slot = ls;
		right_slot = rs;
		immediate = imm;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	function automatic logic [63:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 64'd0;
			1: return 64'd1;
			2: return '1;
			3: return 64'h8000000000000000;
			4: return 64'h7fffffffffffffff;
			5: return 64'($signed($urandom_range(0, 20)) - 10);
			6: return 64'($urandom) << $urandom_range(0, 32);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// One program: mostly well-formed, some noise requests, then a return.
	task automatic run_program(int len, int noise_pct);
		logic [2:0] op;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 99) < noise_pct) begin
				send(3'($urandom), 8'($urandom), 8'($urandom),
					$urandom_range(0, 1) ? {$urandom, $urandom} : 64'd0);
			end else if (i < 2 || $urandom_range(0, 2) == 0) begin
				send(OP_CONST, 8'($urandom), 8'($urandom), pick_value());
			end else begin
				op = 3'($urandom_range(OP_ADD, OP_NEG));
				send(op, 8'($urandom_range(0, i - 1)), 8'($urandom_range(0, i - 1)), 64'd0);
			end
		end
		send(OP_RET, len > 0 ? 8'($urandom_range(0, len - 1)) : 8'd0, 8'($urandom), 64'd0);
	endtask

	task automatic wait_drained();
		in_valid = 0;
		while (sb.outstanding() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		int sent;
		int len;
		sb = new();
		in_valid = 0;
		opcode = OP_CONST;
		left_slot = 0;
		right_slot = 0;
		immediate = 0;
		out_stall = 0;
		hold_req = 0;
		hold_left = 0;
		quiet_cycles = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: each fault kind, the remainder corner, invalid forms.
		send(OP_CONST, 8'hff, 8'hff, 64'h7fffffffffffffff);
		send(OP_CONST, 0, 0, 64'd1);
		send(OP_ADD, 0, 1, 0);			// add overflow
		send(OP_NEG, 0, 0, 0);
		send(OP_RET, 3, 0, 0);
		send(OP_CONST, 0, 0, 64'h8000000000000000);
		send(OP_NEG, 0, 0, 0);			// negation overflow
		send(OP_RET, 0, 0, 0);
		send(OP_CONST, 0, 0, 64'd5);
		send(OP_CONST, 0, 0, 64'd0);
		send(OP_REM, 0, 1, 0);			// divide by zero
		send(OP_RET, 0, 0, 0);
		send(OP_CONST, 0, 0, 64'h8000000000000000);
		send(OP_CONST, 0, 0, '1);
		send(OP_REM, 0, 1, 0);			// min rem -1 gives zero
		send(OP_MUL, 0, 1, 0);			// min * -1 overflows, fault after ok rem
		send(OP_SUB, 0, 1, 0);
		send(OP_RET, 2, 0, 0);
		send(OP_RET, 0, 0, 0);			// return at position zero
		send(OP_BAD, 0, 0, 0);
		send(OP_RET, 0, 0, 0);
		send(OP_CONST, 0, 0, 64'd3);
		send(OP_ADD, 0, 0, 64'd9);		// stray immediate
		send(OP_RET, 1, 0, 0);
		wait_drained();

		// Position overflow: fill every slot, then one more.
		for (int i = 0; i < SLOT_COUNT + 1; i++) send(OP_CONST, 0, 0, {$urandom, $urandom});
		send(OP_RET, 0, 0, 0);
		wait_drained();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 87 : 0;
			recv_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 28 : 0;
			sent = 0;
			while (sent < 200) begin
				len = $urandom_range(0, 12);
				if (phase == 0 && sent > 100 && sent < 115) hold_req = 1;
				run_program(len, 10);
				sent += len + 1;
			end
			wait_drained();		// sender pauses until every result is in
		end

		if (sb.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
